/* sv/cbm_pkg.sv */
// Shared types and constants for the cartridge bank mapper.
// Used by the interfaces, the controller, the datapath and the top level.
package cbm_pkg;

  // Field widths
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned LineW    = 9;
  localparam int unsigned PrgPageW = 9;
  localparam int unsigned ChrPageW = 11;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned NumPrg   = 2;
  localparam int unsigned NumChr   = 8;
  localparam int unsigned CfgIdxW  = 1;

  // Dividend of the page modulo: data, or data doubled for a 2K pair
  localparam int unsigned DvdW = 9;
  localparam int unsigned CntW = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPrgSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgChrSize = 1'b1;

  localparam logic [CfgW-1:0] PrgSizeRst = 8'd2;
  localparam logic [CfgW-1:0] ChrSizeRst = 8'd1;

  // Register decode
  localparam logic [AddrW-1:0] AddrMask   = 16'hE003;
  localparam logic [AddrW-1:0] AddrPrg0   = 16'h8000;
  localparam logic [AddrW-1:0] AddrPrg1   = 16'h8001;
  localparam logic [AddrW-1:0] AddrChrP0  = 16'h8002;
  localparam logic [AddrW-1:0] AddrChrP1  = 16'h8003;
  localparam logic [AddrW-1:0] AddrChr4   = 16'hA000;
  localparam logic [AddrW-1:0] AddrChr5   = 16'hA001;
  localparam logic [AddrW-1:0] AddrChr6   = 16'hA002;
  localparam logic [AddrW-1:0] AddrChr7   = 16'hA003;
  localparam logic [AddrW-1:0] AddrIrqVal = 16'hC000;
  localparam logic [AddrW-1:0] AddrIrqRld = 16'hC001;
  localparam logic [AddrW-1:0] AddrIrqEn  = 16'hC002;
  localparam logic [AddrW-1:0] AddrIrqDis = 16'hC003;
  localparam logic [AddrW-1:0] AddrMirror = 16'hE000;

  localparam logic [DataW-1:0] IrqInvert  = 8'hFF;
  localparam int unsigned      MirrorBit  = 6;
  localparam logic [LineW-1:0] LastVisLine = 9'd239;

  // Operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpTick  = 1'b1;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_PRG,
    WR_CHR_PAIR,
    WR_CHR_ONE,
    WR_IRQ_VALUE,
    WR_IRQ_RELOAD,
    WR_IRQ_ENABLE,
    WR_IRQ_DISABLE,
    WR_MIRROR
  } wr_kind_e;

  function automatic wr_kind_e decode_wr(input logic [AddrW-1:0] addr);
    wr_kind_e k;
    k = WR_NONE;
    case (addr & AddrMask)
      AddrPrg0, AddrPrg1:                     k = WR_PRG;
      AddrChrP0, AddrChrP1:                   k = WR_CHR_PAIR;
      AddrChr4, AddrChr5, AddrChr6, AddrChr7: k = WR_CHR_ONE;
      AddrIrqVal:                             k = WR_IRQ_VALUE;
      AddrIrqRld:                             k = WR_IRQ_RELOAD;
      AddrIrqEn:                              k = WR_IRQ_ENABLE;
      AddrIrqDis:                             k = WR_IRQ_DISABLE;
      AddrMirror:                             k = WR_MIRROR;
      default:                                k = WR_NONE;
    endcase
    return k;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture an input transaction, seed the divider
    logic div_step;  // one restoring division step
    logic apply;     // update mapper state
    logic load_out;  // load result register
  } cbm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_free;
  } cbm_stat_t;

endpackage

/* sv/cbm_if.sv */
// Valid/ready channel interfaces for the bank mapper.
// Depends on cbm_pkg for field widths.
interface cbm_in_if import cbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [AddrW-1:0]     address;
  logic [DataW-1:0]     write_data;
  logic [LineW-1:0]     scanline;
  logic                 rendering_on;

  modport source (output valid, operation, address, write_data, scanline, rendering_on,
                  input ready);
  modport sink   (input valid, operation, address, write_data, scanline, rendering_on,
                  output ready);
endinterface

interface cbm_out_if import cbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PrgPageW-1:0] prg_page_8000;
  logic [PrgPageW-1:0] prg_page_a000;
  logic [ChrPageW-1:0] chr_page_0;
  logic [ChrPageW-1:0] chr_page_1;
  logic [ChrPageW-1:0] chr_page_2;
  logic [ChrPageW-1:0] chr_page_3;
  logic [ChrPageW-1:0] chr_page_4;
  logic [ChrPageW-1:0] chr_page_5;
  logic [ChrPageW-1:0] chr_page_6;
  logic [ChrPageW-1:0] chr_page_7;
  logic                mirror_horizontal;
  logic                irq_line;

  modport source (output valid, prg_page_8000, prg_page_a000, chr_page_0, chr_page_1,
                  chr_page_2, chr_page_3, chr_page_4, chr_page_5, chr_page_6,
                  chr_page_7, mirror_horizontal, irq_line,
                  input ready);
  modport sink   (input valid, prg_page_8000, prg_page_a000, chr_page_0, chr_page_1,
                  chr_page_2, chr_page_3, chr_page_4, chr_page_5, chr_page_6,
                  chr_page_7, mirror_horizontal, irq_line,
                  output ready);
endinterface

/* sv/cbm_ctrl.sv */
// Sequencing controller for the bank mapper: accept, divide, apply, emit.
// Depends on cbm_pkg for the command and status structs.
module cbm_ctrl import cbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cbm_stat_t stat_i,
  output cbm_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_APPLY,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = stat_i.needs_div;
        if (!stat_i.needs_div || stat_i.div_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/cbm_datapath.sv */
// Datapath of the bank mapper: input capture, page modulo divider,
// mapper and interrupt state, configuration and result register.
// Depends on cbm_pkg.
module cbm_datapath import cbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // input payload
  input  logic                operation_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic [DataW-1:0]    write_data_i,
  input  logic [LineW-1:0]    scanline_i,
  input  logic                rendering_on_i,
  // control
  input  cbm_cmd_t            cmd_i,
  output cbm_stat_t           stat_o,
  // result
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [PrgPageW-1:0] prg_page_o [NumPrg],
  output logic [ChrPageW-1:0] chr_page_o [NumChr],
  output logic                mirror_horizontal_o,
  output logic                irq_line_o
);

  // Configuration
  logic [CfgW-1:0] prg_size_q, chr_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_size_q <= PrgSizeRst;
      chr_size_q <= ChrSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPrgSize: prg_size_q <= cfg_wdata_i;
        CfgChrSize: chr_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured transaction
  logic             op_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] data_q;
  logic [LineW-1:0] line_q;
  logic             rend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      addr_q <= address_i;
      data_q <= write_data_i;
      line_q <= scanline_i;
      rend_q <= rendering_on_i;
    end
  end

  wr_kind_e kind, kind_in;
  logic     is_wr;
  assign kind    = decode_wr(addr_q);
  assign kind_in = decode_wr(address_i);
  assign is_wr   = (op_q == OpWrite);

  // Page moduli: 2*prg for program pages, 8*chr for character pages
  logic [ChrPageW-1:0] prg_mod, chr_mod, divisor;
  assign prg_mod = {2'b00, prg_size_q, 1'b0};
  assign chr_mod = {chr_size_q, 3'b000};
  assign divisor = (kind == WR_PRG) ? prg_mod : chr_mod;

  assign stat_o.needs_div = is_wr &&
      (((kind == WR_PRG) && (prg_size_q != '0)) ||
       (((kind == WR_CHR_PAIR) || (kind == WR_CHR_ONE)) && (chr_size_q != '0)));

  // Restoring divider, one dividend bit per cycle, remainder only
  logic [DvdW-1:0]     dvd_q;
  logic [CntW-1:0]     cnt_q;
  logic [ChrPageW-1:0] rem_q;
  logic [ChrPageW:0]   trial;

  assign trial           = {rem_q, dvd_q[DvdW-1]};
  assign stat_o.div_last = (cnt_q == CntW'(DvdW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      // a 2K pair divides twice the data; its odd page follows from that
      dvd_q <= (kind_in == WR_CHR_PAIR) ? {write_data_i, 1'b0} : {1'b0, write_data_i};
      cnt_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem_q <= ChrPageW'(trial - {1'b0, divisor});
      end else begin
        rem_q <= trial[ChrPageW-1:0];
      end
    end
  end

  // Odd page of a pair wraps to zero at the modulus
  logic [ChrPageW-1:0] rem_inc;
  assign rem_inc = (rem_q + 1'b1 == chr_mod) ? '0 : rem_q + 1'b1;

  // Scanline counter next value
  logic             tick_en;
  logic [DataW-1:0] cnt_next;
  logic [DataW-1:0] irq_cnt_q, irq_val_q;
  logic             armed_q, enabled_q, pending_q, mirror_q;

  assign tick_en = (op_q == OpTick) && (line_q <= LastVisLine) && rend_q;

  always_comb begin
    if (armed_q) begin
      cnt_next = irq_val_q;
    end else if (irq_cnt_q != '0) begin
      cnt_next = irq_cnt_q - 1'b1;
    end else begin
      cnt_next = irq_cnt_q;
    end
  end

  // Mapper and interrupt state
  logic [PrgPageW-1:0] prg_q [NumPrg];
  logic [ChrPageW-1:0] chr_q [NumChr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPrg; i++) prg_q[i] <= PrgPageW'(i);
      for (int i = 0; i < NumChr; i++) chr_q[i] <= ChrPageW'(i);
      irq_val_q <= '0;
      irq_cnt_q <= '0;
      armed_q   <= 1'b0;
      enabled_q <= 1'b0;
      pending_q <= 1'b0;
      mirror_q  <= 1'b0;
    end else if (cmd_i.apply) begin
      if (is_wr) begin
        case (kind)
          WR_PRG: begin
            if (stat_o.needs_div) prg_q[addr_q[0]] <= rem_q[PrgPageW-1:0];
          end
          WR_CHR_PAIR: begin
            if (stat_o.needs_div) begin
              chr_q[{1'b0, addr_q[0], 1'b0}] <= rem_q;
              chr_q[{1'b0, addr_q[0], 1'b1}] <= rem_inc;
            end
          end
          WR_CHR_ONE: begin
            if (stat_o.needs_div) chr_q[{1'b1, addr_q[1:0]}] <= rem_q;
          end
          WR_IRQ_VALUE: begin
            irq_val_q <= data_q ^ IrqInvert;
            pending_q <= 1'b0;
          end
          WR_IRQ_RELOAD: begin
            armed_q   <= 1'b1;
            pending_q <= 1'b0;
          end
          WR_IRQ_ENABLE: enabled_q <= 1'b1;
          WR_IRQ_DISABLE: begin
            enabled_q <= 1'b0;
            pending_q <= 1'b0;
          end
          WR_MIRROR: mirror_q <= data_q[MirrorBit];
          default: ;
        endcase
      end else if (tick_en) begin
        irq_cnt_q <= cnt_next;
        armed_q   <= 1'b0;
        if (cnt_next == '0) begin
          armed_q <= 1'b1;
          if (enabled_q) pending_q <= 1'b1;
        end
      end
    end
  end

  // Result register
  logic out_valid_q;

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      prg_page_o          <= prg_q;
      chr_page_o          <= chr_q;
      mirror_horizontal_o <= mirror_q;
      irq_line_o          <= pending_q;
    end
  end

endmodule

/* sv/cartridge_bank_mapper_scanline_irq.sv */
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Depends on cbm_pkg, cbm_if, cbm_ctrl and cbm_datapath.
//
// Usage:
//   in_i carries one transaction per CPU register write (operation 0) or
//   scanline tick (operation 1); out_o returns exactly one result
//   per transaction with all page selects, the mirroring and the IRQ line.
//   Configuration (program and character ROM size) is written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no transaction is in flight.
// Sequencing:
//   A page write with a nonzero ROM size runs nine divider steps of the
//   bit-serial page modulo, then apply and result load; any other transaction
//   skips the divider steps. One transaction is in work at a time, and the
//   controller returns to idle before it accepts the next.
// Reset:
//   rst_ni clears the pages to their power-on mapping (program 0 and 1,
//   character 0..7), the IRQ state and mirroring, and sets the sizes to
//   32K program and 8K character ROM. No result is pending after reset.
// Back-pressure:
//   The result sits in an output register until taken; a new transaction is
//   accepted meanwhile, and its result waits for that register to free up.
module cartridge_bank_mapper_scanline_irq import cbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  cbm_in_if.sink             in_i,
  cbm_out_if.source          out_o
);

  cbm_cmd_t  cmd;
  cbm_stat_t stat;

  logic [PrgPageW-1:0] prg_page [NumPrg];
  logic [ChrPageW-1:0] chr_page [NumChr];

  cbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cbm_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .operation_i         (in_i.operation),
    .address_i           (in_i.address),
    .write_data_i        (in_i.write_data),
    .scanline_i          (in_i.scanline),
    .rendering_on_i      (in_i.rendering_on),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .prg_page_o          (prg_page),
    .chr_page_o          (chr_page),
    .mirror_horizontal_o (out_o.mirror_horizontal),
    .irq_line_o          (out_o.irq_line)
  );

  assign out_o.prg_page_8000 = prg_page[0];
  assign out_o.prg_page_a000 = prg_page[1];
  assign out_o.chr_page_0    = chr_page[0];
  assign out_o.chr_page_1    = chr_page[1];
  assign out_o.chr_page_2    = chr_page[2];
  assign out_o.chr_page_3    = chr_page[3];
  assign out_o.chr_page_4    = chr_page[4];
  assign out_o.chr_page_5    = chr_page[5];
  assign out_o.chr_page_6    = chr_page[6];
  assign out_o.chr_page_7    = chr_page[7];

endmodule

/* dv/tb_cartridge_bank_mapper_scanline_irq.sv */
// Self-checking testbench for the cartridge bank mapper with its scanline IRQ counter.
// It drives CPU register writes and scanline ticks, predicts every result and compares it.
// Depends on cbm_pkg, the cbm_in_if/cbm_out_if interfaces and the mapper RTL.
module tb_cartridge_bank_mapper_scanline_irq import cbm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Snapshot of everything a result reports
  typedef struct {
    logic [PrgPageW-1:0] prg [NumPrg];
    logic [ChrPageW-1:0] chr [NumChr];
    logic                mirror;
    logic                irq;
  } map_view_t;

  // Registers that select page slots; address bits outside AddrMask are don't-care
  localparam logic [AddrW-1:0] PageRegs [8] = '{AddrPrg0, AddrPrg1, AddrChrP0, AddrChrP1,
                                                AddrChr4, AddrChr5, AddrChr6, AddrChr7};
  // IRQ registers, value and enable weighted up, disable kept rarer
  localparam logic [AddrW-1:0] IrqRegs [6] = '{AddrIrqVal, AddrIrqVal, AddrIrqRld,
                                               AddrIrqEn, AddrIrqEn, AddrIrqDis};
  // ROM size settings per random phase; the last phase picks its own
  localparam logic [CfgW-1:0] PrgSweep [6] = '{8'd2, 8'd1, 8'd255, 8'd1, 8'd255, 8'd3};
  localparam logic [CfgW-1:0] ChrSweep [6] = '{8'd1, 8'd0, 8'd255, 8'd255, 8'd0, 8'd5};
  localparam int unsigned ItemsPerPhase = 165;
  localparam int unsigned SettleCycles  = 16;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  cbm_in_if  in_ch ();
  cbm_out_if out_ch ();

  cartridge_bank_mapper_scanline_irq dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Mapper prediction state
  logic [CfgW-1:0]     prg_rom_size;
  logic [CfgW-1:0]     chr_rom_size;
  logic [PrgPageW-1:0] prg_bank [NumPrg];
  logic [ChrPageW-1:0] chr_bank [NumChr];
  logic [7:0]          irq_latch;
  logic [7:0]          scan_count;
  logic                reload_due;
  logic                irq_allowed;
  logic                irq_raised;
  logic                mirror_h;

  map_view_t pending_views [$];
  int unsigned err_count;
  int unsigned burst_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_cartridge_bank_mapper_scanline_irq: FAIL");
    $finish;
  end

  function automatic void reset_mapper_state();
    prg_rom_size = PrgSizeRst;
    chr_rom_size = ChrSizeRst;
    for (int i = 0; i < NumPrg; i++) prg_bank[i] = PrgPageW'(i);
    for (int i = 0; i < NumChr; i++) chr_bank[i] = ChrPageW'(i);
    irq_latch   = '0;
    scan_count  = '0;
    reload_due  = 1'b0;
    irq_allowed = 1'b0;
    irq_raised  = 1'b0;
    mirror_h    = 1'b0;
  endfunction

  // Effect of one CPU register write
  function automatic void cpu_write_effect(input logic [AddrW-1:0] addr,
                                           input logic [DataW-1:0] data);
    int unsigned prg_mod;
    int unsigned chr_mod;
    logic [AddrW-1:0] reg_sel;
    prg_mod = 2 * prg_rom_size;
    chr_mod = 8 * chr_rom_size;
    reg_sel = addr & AddrMask;
    case (reg_sel)
      AddrPrg0, AddrPrg1: begin
        if (prg_mod != 0) prg_bank[reg_sel[0]] = PrgPageW'(data % prg_mod);
      end
      AddrChrP0, AddrChrP1: begin
        // 2K pair: even and odd 1K halves
        if (chr_mod != 0) begin
          chr_bank[2 * reg_sel[0]]     = ChrPageW'((2 * data) % chr_mod);
          chr_bank[2 * reg_sel[0] + 1] = ChrPageW'((2 * data + 1) % chr_mod);
        end
      end
      AddrChr4, AddrChr5, AddrChr6, AddrChr7: begin
        if (chr_mod != 0) chr_bank[4 + reg_sel[1:0]] = ChrPageW'(data % chr_mod);
      end
      AddrIrqVal: begin
        irq_latch  = data ^ IrqInvert;
        irq_raised = 1'b0;
      end
      AddrIrqRld: begin
        reload_due = 1'b1;
        irq_raised = 1'b0;
      end
      AddrIrqEn: irq_allowed = 1'b1;
      AddrIrqDis: begin
        irq_allowed = 1'b0;
        irq_raised  = 1'b0;
      end
      AddrMirror: mirror_h = data[MirrorBit];
      default: ;
    endcase
  endfunction

  // Effect of one scanline tick
  function automatic void scanline_effect(input logic [LineW-1:0] line, input logic rend);
    if (line <= LastVisLine && rend) begin
      if (reload_due) begin
        scan_count = irq_latch;
        reload_due = 1'b0;
      end else if (scan_count != 0) begin
        scan_count = scan_count - 8'd1;
      end
      if (scan_count == 0) begin
        if (irq_allowed) irq_raised = 1'b1;
        reload_due = 1'b1;
      end
    end
  endfunction

  function automatic map_view_t mapper_view();
    map_view_t v;
    v.prg    = prg_bank;
    v.chr    = chr_bank;
    v.mirror = mirror_h;
    v.irq    = irq_raised;
    return v;
  endfunction

  function automatic map_view_t observed_view();
    map_view_t v;
    v.prg[0] = out_ch.prg_page_8000;
    v.prg[1] = out_ch.prg_page_a000;
    v.chr[0] = out_ch.chr_page_0;
    v.chr[1] = out_ch.chr_page_1;
    v.chr[2] = out_ch.chr_page_2;
    v.chr[3] = out_ch.chr_page_3;
    v.chr[4] = out_ch.chr_page_4;
    v.chr[5] = out_ch.chr_page_5;
    v.chr[6] = out_ch.chr_page_6;
    v.chr[7] = out_ch.chr_page_7;
    v.mirror = out_ch.mirror_horizontal;
    v.irq    = out_ch.irq_line;
    return v;
  endfunction

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want)
      flag_error($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
  endfunction

  // Result checker: every result transaction against the oldest prediction
  always @(posedge clk_i) begin
    map_view_t want;
    map_view_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_views.size() == 0) begin
        flag_error("result transaction with no prediction outstanding");
      end else begin
        want = pending_views.pop_front();
        got  = observed_view();
        check_field("prg_page_8000", 16'(want.prg[0]), 16'(got.prg[0]));
        check_field("prg_page_a000", 16'(want.prg[1]), 16'(got.prg[1]));
        for (int i = 0; i < NumChr; i++)
          check_field($sformatf("chr_page_%0d", i), 16'(want.chr[i]), 16'(got.chr[i]));
        check_field("mirror_horizontal", 16'(want.mirror), 16'(got.mirror));
        check_field("irq_line", 16'(want.irq), 16'(got.irq));
      end
    end
  end

  // Receiver: ready follows a repeating pattern, swapped now and then; bit 0 is
  // always set so ready rises at least once per pass through the pattern
  initial begin
    logic [15:0] ready_pattern;
    int unsigned pattern_left;
    int unsigned pattern_pos;
    out_ch.ready  = 1'b0;
    pattern_left  = 0;
    pattern_pos   = 0;
    ready_pattern = '1;
    forever begin
      @(negedge clk_i);
      if (pattern_left == 0) begin
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
        pattern_left  = $urandom_range(32, 256);
      end
      pattern_left--;
      out_ch.ready = ready_pattern[pattern_pos % 16];
      pattern_pos++;
    end
  end

  // Send one transaction; bursts of random length with idle gaps between them
  task automatic send_item(input logic op, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] data, input logic [LineW-1:0] line,
                           input logic rend);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.operation    = op;
    in_ch.address      = addr;
    in_ch.write_data   = data;
    in_ch.scanline     = line;
    in_ch.rendering_on = rend;
    in_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == OpWrite) cpu_write_effect(addr, data);
    else scanline_effect(line, rend);
    pending_views.push_back(mapper_view());
  endtask

  task automatic cpu_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    send_item(OpWrite, addr, data, 9'($urandom), 1'($urandom));
  endtask

  task automatic tick(input logic [LineW-1:0] line, input logic rend);
    send_item(OpTick, 16'($urandom), 8'($urandom), line, rend);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_views.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ROM sizes change only while the block is idle
  task automatic set_rom_sizes(input logic [CfgW-1:0] prg, input logic [CfgW-1:0] chr);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CfgPrgSize;
    cfg_wdata_i = prg;
    @(negedge clk_i);
    cfg_idx_i   = CfgChrSize;
    cfg_wdata_i = chr;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    prg_rom_size = prg;
    chr_rom_size = chr;
  endtask

  // Power-on mapping, seen through transactions that change nothing
  task automatic test_reset_view();
    tick(9'd100, 1'b0);
    cpu_write(16'h7FFF, 8'hFF);
  endtask

  // Every page register, the extremes of the data and aliased addresses
  task automatic test_page_registers();
    cpu_write(AddrPrg0, 8'hFF);
    cpu_write(16'h9FFD, 8'h00);
    cpu_write(AddrChrP0, 8'hFF);
    cpu_write(AddrChrP1, 8'h80);
    cpu_write(AddrChr4, 8'hFF);
    cpu_write(AddrChr5, 8'h00);
    cpu_write(AddrChr6, 8'h55);
    cpu_write(16'hBFFF, 8'h7F);
    cpu_write(AddrMirror, 8'h40);
    cpu_write(AddrMirror, 8'hBF);
    cpu_write(16'hFFFF, 8'hFF);
  endtask

  // Counter reload, countdown, request, acknowledge and ignored ticks
  task automatic test_irq_counter();
    cpu_write(AddrIrqVal, 8'hFD);
    cpu_write(AddrIrqEn, 8'h00);
    cpu_write(AddrIrqRld, 8'h00);
    tick(9'd0, 1'b1);
    tick(9'd239, 1'b1);
    tick(9'd240, 1'b1);
    tick(9'd511, 1'b1);
    tick(9'd10, 1'b0);
    tick(9'd120, 1'b1);
    tick(9'd5, 1'b1);
    cpu_write(AddrIrqVal, 8'h00);
    cpu_write(AddrIrqDis, 8'hFF);
  endtask

  // Smallest program ROM with character RAM, then the largest ROMs
  task automatic test_rom_sizes();
    set_rom_sizes(8'd1, 8'd0);
    cpu_write(AddrPrg1, 8'hFF);
    cpu_write(AddrChrP0, 8'h13);
    set_rom_sizes(8'd255, 8'd255);
    cpu_write(AddrChrP1, 8'hFF);
    cpu_write(AddrChr7, 8'hFF);
  endtask

  // One random transaction, mostly well-formed with random content
  task automatic send_random_item();
    int unsigned pick;
    logic [AddrW-1:0] alias_bits;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [LineW-1:0] line;
    logic rend;
    pick       = $urandom_range(0, 99);
    alias_bits = 16'($urandom) & ~AddrMask;
    data       = 8'($urandom);
    line       = 9'($urandom);
    rend       = ($urandom_range(0, 7) != 0);
    if (pick < 45) begin
      // mostly visible lines so the counter keeps moving
      if ($urandom_range(0, 9) != 0) line = 9'($urandom_range(0, LastVisLine));
      send_item(OpTick, 16'($urandom), data, line, rend);
    end else if (pick < 70) begin
      send_item(OpWrite, PageRegs[$urandom_range(0, 7)] | alias_bits, data, line, rend);
    end else if (pick < 90) begin
      addr = IrqRegs[$urandom_range(0, 5)];
      // short reload values reach zero often
      if (addr == AddrIrqVal && $urandom_range(0, 3) != 0)
        data = DataW'(IrqInvert - $urandom_range(0, 6));
      send_item(OpWrite, addr | alias_bits, data, line, rend);
    end else if (pick < 95) begin
      send_item(OpWrite, AddrMirror | alias_bits, data, line, rend);
    end else begin
      send_item(OpWrite, 16'($urandom), data, line, rend);
    end
  endtask

  // Random traffic over a sweep of ROM sizes
  task automatic test_random_traffic();
    for (int p = 0; p <= 6; p++) begin
      if (p < 6) set_rom_sizes(PrgSweep[p], ChrSweep[p]);
      else set_rom_sizes(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      repeat (ItemsPerPhase) send_random_item();
    end
  endtask

  // Test sequence
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgPrgSize;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OpWrite;
    in_ch.address      = '0;
    in_ch.write_data   = '0;
    in_ch.scanline     = '0;
    in_ch.rendering_on = 1'b0;
    err_count          = 0;
    burst_left         = 0;
    reset_mapper_state();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_view();
    test_page_registers();
    test_irq_counter();
    test_rom_sizes();
    test_random_traffic();
    wait_drained();

    if (err_count == 0) begin
      $display("tb_cartridge_bank_mapper_scanline_irq: PASS");
    end else begin
      $display("tb_cartridge_bank_mapper_scanline_irq: FAIL");
    end
    $finish;
  end

endmodule
